>>> rtl/esm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_pkg
// shared widths, codes and types of the embedding slot swap manager
// ----------------------------------------------------------------------------
package esm_pkg;

    localparam int KEY_W      = 64;
    localparam int VER_W      = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 3;
    localparam int PSLOT_W    = 12;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int S_DATA_W   = 112;
    localparam int M_DATA_W   = 80;

    localparam logic [KEY_W-1:0] KEY_INVALID = {KEY_W{1'b1}};

    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OP_W-1:0] OP_PLACE  = 3'd1;
    localparam logic [OP_W-1:0] OP_END    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_GETKEY = 3'd4;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PLACED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADKEY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOVICTIM = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_USED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_START  = 1'd1;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_FIND  = 7'b0000100,
        S_VIC1  = 7'b0001000,
        S_VIC2  = 7'b0010000,
        S_MOD   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        K_HIT,
        K_REM,
        K_FILL,
        K_VICT,
        K_GET
    } mod_kind_t;

endpackage

>>> rtl/esm_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_row_mem
// one-write one-read synchronous row memory, registered read data
// ----------------------------------------------------------------------------
module esm_row_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 386
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/esm_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esm_scan
// walks slot rows one a cycle, stops at the first key match or victim
// ----------------------------------------------------------------------------
module esm_scan #(
    parameter int SLOT_W = 12,
    parameter int CNT_W  = 13
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [CNT_W-1:0]          from_idx,
    input  logic [CNT_W-1:0]          to_idx,
    input  logic                      by_key,
    input  logic [esm_pkg::KEY_W-1:0] key,
    input  logic [esm_pkg::VER_W-1:0] bv,
    input  logic [esm_pkg::KEY_W-1:0] cand_key,
    input  logic [esm_pkg::VER_W-1:0] cand_ver,
    output logic                      rd_en,
    output logic [SLOT_W-1:0]         rd_addr,
    output logic                      done,
    output logic                      found,
    output logic [SLOT_W-1:0]         found_idx
);

    logic              busy_reg;
    logic              pend_reg;
    logic              mode_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  to_reg;
    logic [SLOT_W-1:0] pidx_reg;
    logic              done_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] fidx_reg;
    logic              match;
    logic              hit;
    logic              more;

    // victim rule: newest version older than current minus one
    assign match = mode_reg ? (cand_key == key)
                            : ((bv >= 32'd2) && (cand_ver < (bv - 32'd1)));
    assign hit     = busy_reg && pend_reg && match;
    assign more    = idx_reg < to_reg;
    assign rd_en   = busy_reg && !hit && more;
    assign rd_addr = idx_reg[SLOT_W-1:0];

    assign done      = done_reg;
    assign found     = found_reg;
    assign found_idx = fidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            mode_reg  <= 1'b0;
            idx_reg   <= '0;
            to_reg    <= '0;
            pidx_reg  <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            fidx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                pend_reg  <= 1'b0;
                idx_reg   <= from_idx;
                to_reg    <= to_idx;
                mode_reg  <= by_key;
                found_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (hit)
                begin
                    busy_reg  <= 1'b0;
                    pend_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    found_reg <= 1'b1;
                    fidx_reg  <= pidx_reg;
                end
                else if (more)
                begin
                    pend_reg <= 1'b1;
                    pidx_reg <= idx_reg[SLOT_W-1:0];
                    idx_reg  <= idx_reg + 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_reg <= 1'b0;
                end
                else
                begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    found_reg <= 1'b0;
                end
            end
        end
    end

endmodule

>>> rtl/embedding_slot_swap_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// embedding_slot_swap_manager_top
// clock-replacement slot cache with a short per-slot version history
// ----------------------------------------------------------------------------
// usage
//   input items arrive on s_tvalid/s_tready/s_tdata/s_tuser (opcode in tuser),
//   one result item per input leaves on m_tvalid/m_tready/m_tdata/m_tuser
//   (status in tuser). configuration goes through cfg_we/cfg_index/cfg_data.
// processing
//   one item is worked on at a time. lookup, place and remove search the key
//   map by reading one slot row per cycle from the row memory, stopping early
//   on a match. a place into a full cache adds a victim walk from the clock
//   hand, then if need be from the start offset, of up to 2 * cache_slots_used
//   more row reads. the row memory has a single read port.
// reset
//   after reset a clearing pass writes every slot row while s_tready stays
//   low; configuration writes are taken during it.
// stalls
//   the result sits in an output register; while m_tready is low it waits
//   there, the next item may be taken and worked on but holds in its last
//   step until the register frees, and s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module embedding_slot_swap_manager_top #(
    parameter int SLOTS         = 4096,
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // item_key [63:0], evict_only [64], query_slot [76:65], query_version [108:77]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [esm_pkg::S_DATA_W-1:0]    s_tdata,
    // opcode [2:0]
    input  logic [esm_pkg::OP_W-1:0]        s_tuser,
    // slot [11:0], swapped_out [12], out_key [76:13]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [esm_pkg::M_DATA_W-1:0]    m_tdata,
    // status [2:0]
    output logic [esm_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                            cfg_we,
    input  logic [esm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [esm_pkg::CFG_W-1:0]       cfg_data
);

    localparam int H      = HISTORY_DEPTH;
    localparam int HW     = $clog2(HISTORY_DEPTH);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = (SLOT_W + 1 > 13) ? SLOT_W + 1 : 13;
    localparam int KW     = esm_pkg::KEY_W;
    localparam int VW     = esm_pkg::VER_W;

    // one memory row holds a slot's whole ring and its head
    typedef struct packed {
        logic [HW-1:0]         head;
        logic [H-1:0][VW-1:0]  vers;
        logic [H-1:0][KW-1:0]  keys;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // input fields
    logic [KW-1:0]              in_key;
    logic                       in_evict;
    logic [esm_pkg::PSLOT_W-1:0] in_qslot;
    logic [VW-1:0]              in_qver;

    assign in_key   = s_tdata[63:0];
    assign in_evict = s_tdata[64];
    assign in_qslot = s_tdata[76:65];
    assign in_qver  = s_tdata[108:77];

    esm_pkg::state_t             state_reg;
    esm_pkg::mod_kind_t          kind_reg;
    logic [esm_pkg::OP_W-1:0]    op_reg;
    logic [KW-1:0]               key_reg;
    logic                        evict_reg;
    logic [VW-1:0]               qver_reg;
    logic [VW-1:0]               bv_reg;
    logic [CNT_W-1:0]            filled_reg;
    logic [CNT_W-1:0]            hand_reg;
    logic [esm_pkg::CFG_W-1:0]   csu_reg;
    logic [esm_pkg::PSLOT_W-1:0] rstart_reg;
    logic [SLOT_W-1:0]           tgt_reg;
    logic [SLOT_W-1:0]           clr_reg;
    logic [esm_pkg::STATUS_W-1:0] res_status_reg;
    logic [esm_pkg::PSLOT_W-1:0] res_slot_reg;
    logic                        res_swap_reg;
    logic [KW-1:0]               res_key_reg;
    logic                        m_tvalid_reg;
    logic [esm_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [esm_pkg::STATUS_W-1:0] m_tuser_reg;

    // memory ports
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;
    logic [ROW_W-1:0]  mem_rdata;

    // scan unit
    logic              scan_start;
    logic [CNT_W-1:0]  scan_from;
    logic [CNT_W-1:0]  scan_to;
    logic              scan_by_key;
    logic              scan_rd_en;
    logic [SLOT_W-1:0] scan_rd_addr;
    logic              scan_done;
    logic              scan_found;
    logic [SLOT_W-1:0] scan_idx;

    logic              top_re;
    logic [SLOT_W-1:0] top_raddr;

    // row views
    row_t          rd_row;
    row_t          add_row;
    row_t          rem_row;
    row_t          clr_row;
    logic [HW-1:0] newest;
    logic [KW-1:0] newest_key;
    logic [VW-1:0] newest_ver;
    logic          gk_found;
    logic [KW-1:0] gk_key;

    logic             accept;
    logic             key_op;
    logic             in_range;
    logic [CNT_W-1:0] lim;
    logic             can_fill;

    assign s_tready = (state_reg == esm_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign key_op   = (s_tuser == esm_pkg::OP_LOOKUP) || (s_tuser == esm_pkg::OP_PLACE) ||
                      (s_tuser == esm_pkg::OP_REMOVE);
    assign in_range = (CNT_W'(in_qslot) < filled_reg) && (CNT_W'(in_qslot) < CNT_W'(SLOTS));
    // slot limit: register value capped at the memory size
    assign lim      = (CNT_W'(csu_reg) > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(csu_reg);
    assign can_fill = filled_reg < lim;

    assign rd_row     = row_t'(mem_rdata);
    assign newest     = (rd_row.head == '0) ? HW'(H - 1) : rd_row.head - 1'b1;
    assign newest_key = rd_row.keys[newest];
    assign newest_ver = rd_row.vers[newest];

    // new record at the ring head
    always_comb
    begin
        add_row = rd_row;
        add_row.keys[rd_row.head] = key_reg;
        add_row.vers[rd_row.head] = bv_reg;
        add_row.head = (rd_row.head == HW'(H - 1)) ? '0 : rd_row.head + 1'b1;
    end

    // remove: newest key dropped, older records wiped unless evict only
    always_comb
    begin
        rem_row = rd_row;
        for (int i = 0; i < H; i++)
        begin
            if (HW'(i) == newest)
            begin
                rem_row.keys[i] = esm_pkg::KEY_INVALID;
            end
            else if (!evict_reg)
            begin
                rem_row.keys[i] = esm_pkg::KEY_INVALID;
                rem_row.vers[i] = '0;
            end
        end
    end

    always_comb
    begin
        clr_row.head = '0;
        for (int i = 0; i < H; i++)
        begin
            clr_row.keys[i] = esm_pkg::KEY_INVALID;
            clr_row.vers[i] = '0;
        end
    end

    // get key: newest first, first version below the query
    always_comb
    begin
        int jj;
        jj = 0;
        gk_found = 1'b0;
        gk_key   = esm_pkg::KEY_INVALID;
        for (int i = 0; i < H; i++)
        begin
            jj = int'(rd_row.head) - 1 - i;
            if (jj < 0)
            begin
                jj = jj + H;
            end
            if (!gk_found && (qver_reg > rd_row.vers[HW'(jj)]))
            begin
                gk_found = 1'b1;
                gk_key   = rd_row.keys[HW'(jj)];
            end
        end
    end

    // scan starts and single row reads
    always_comb
    begin
        scan_start  = 1'b0;
        scan_from   = '0;
        scan_to     = CNT_W'(SLOTS);
        scan_by_key = 1'b1;
        top_re      = 1'b0;
        top_raddr   = '0;
        case (state_reg)
            esm_pkg::S_IDLE:
            begin
                if (accept && key_op && (in_key != esm_pkg::KEY_INVALID))
                begin
                    scan_start = 1'b1;
                end
                if (accept && (s_tuser == esm_pkg::OP_GETKEY) && in_range)
                begin
                    top_re    = 1'b1;
                    top_raddr = SLOT_W'(in_qslot);
                end
            end
            esm_pkg::S_FIND:
            begin
                if (scan_done && !scan_found && (op_reg == esm_pkg::OP_PLACE))
                begin
                    if (can_fill)
                    begin
                        top_re    = 1'b1;
                        top_raddr = filled_reg[SLOT_W-1:0];
                    end
                    else
                    begin
                        scan_start  = 1'b1;
                        scan_from   = hand_reg;
                        scan_to     = lim;
                        scan_by_key = 1'b0;
                    end
                end
            end
            esm_pkg::S_VIC1:
            begin
                if (scan_done && !scan_found)
                begin
                    scan_start  = 1'b1;
                    scan_from   = CNT_W'(rstart_reg);
                    scan_to     = lim;
                    scan_by_key = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign mem_re    = scan_rd_en || top_re;
    assign mem_raddr = scan_rd_en ? scan_rd_addr : top_raddr;
    assign mem_we    = (state_reg == esm_pkg::S_CLEAR) ||
                       ((state_reg == esm_pkg::S_MOD) && (kind_reg != esm_pkg::K_GET));
    assign mem_waddr = (state_reg == esm_pkg::S_CLEAR) ? clr_reg : tgt_reg;
    assign mem_wdata = (state_reg == esm_pkg::S_CLEAR) ? ROW_W'(clr_row) :
                       (kind_reg == esm_pkg::K_REM)    ? ROW_W'(rem_row) : ROW_W'(add_row);

    esm_row_mem #(
        .DEPTH (SLOTS),
        .WIDTH (ROW_W)
    ) u_row_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    esm_scan #(
        .SLOT_W (SLOT_W),
        .CNT_W  (CNT_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .from_idx  (scan_from),
        .to_idx    (scan_to),
        .by_key    (scan_by_key),
        .key       (key_reg),
        .bv        (bv_reg),
        .cand_key  (newest_key),
        .cand_ver  (newest_ver),
        .rd_en     (scan_rd_en),
        .rd_addr   (scan_rd_addr),
        .done      (scan_done),
        .found     (scan_found),
        .found_idx (scan_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= esm_pkg::S_CLEAR;
            kind_reg       <= esm_pkg::K_HIT;
            op_reg         <= '0;
            bv_reg         <= '0;
            filled_reg     <= '0;
            hand_reg       <= '0;
            csu_reg        <= esm_pkg::CFG_W'(4096);
            rstart_reg     <= '0;
            clr_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            // a result taken while the next one loads is handled in the finish step
            if (m_tvalid_reg && m_tready && (state_reg != esm_pkg::S_FIN))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                esm_pkg::S_CLEAR:
                begin
                    if (clr_reg == SLOT_W'(SLOTS - 1))
                    begin
                        state_reg <= esm_pkg::S_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                esm_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg         <= s_tuser;
                        key_reg        <= in_key;
                        evict_reg      <= in_evict;
                        qver_reg       <= in_qver;
                        res_status_reg <= esm_pkg::ST_NOTFOUND;
                        res_slot_reg   <= '0;
                        res_swap_reg   <= 1'b0;
                        res_key_reg    <= esm_pkg::KEY_INVALID;
                        state_reg      <= esm_pkg::S_FIN;
                        if (key_op)
                        begin
                            if (in_key == esm_pkg::KEY_INVALID)
                            begin
                                res_status_reg <= esm_pkg::ST_BADKEY;
                            end
                            else
                            begin
                                state_reg <= esm_pkg::S_FIND;
                            end
                        end
                        else if (s_tuser == esm_pkg::OP_END)
                        begin
                            bv_reg         <= bv_reg + 1'b1;
                            res_status_reg <= esm_pkg::ST_DONE;
                        end
                        else if ((s_tuser == esm_pkg::OP_GETKEY) && in_range)
                        begin
                            tgt_reg   <= SLOT_W'(in_qslot);
                            kind_reg  <= esm_pkg::K_GET;
                            state_reg <= esm_pkg::S_MOD;
                        end
                    end
                end
                esm_pkg::S_FIND:
                begin
                    if (scan_done)
                    begin
                        if (scan_found)
                        begin
                            tgt_reg <= scan_idx;
                            if (op_reg == esm_pkg::OP_PLACE)
                            begin
                                // already present: plain hit, no new record
                                res_status_reg <= esm_pkg::ST_HIT;
                                res_slot_reg   <= esm_pkg::PSLOT_W'(scan_idx);
                                state_reg      <= esm_pkg::S_FIN;
                            end
                            else
                            begin
                                kind_reg  <= (op_reg == esm_pkg::OP_LOOKUP) ? esm_pkg::K_HIT
                                                                            : esm_pkg::K_REM;
                                state_reg <= esm_pkg::S_MOD;
                            end
                        end
                        else if (op_reg == esm_pkg::OP_LOOKUP)
                        begin
                            res_status_reg <= esm_pkg::ST_MISS;
                            state_reg      <= esm_pkg::S_FIN;
                        end
                        else if (op_reg == esm_pkg::OP_PLACE)
                        begin
                            if (can_fill)
                            begin
                                tgt_reg   <= filled_reg[SLOT_W-1:0];
                                kind_reg  <= esm_pkg::K_FILL;
                                state_reg <= esm_pkg::S_MOD;
                            end
                            else
                            begin
                                state_reg <= esm_pkg::S_VIC1;
                            end
                        end
                        else
                        begin
                            state_reg <= esm_pkg::S_FIN;
                        end
                    end
                end
                esm_pkg::S_VIC1:
                begin
                    if (scan_done)
                    begin
                        if (scan_found)
                        begin
                            tgt_reg   <= scan_idx;
                            kind_reg  <= esm_pkg::K_VICT;
                            state_reg <= esm_pkg::S_MOD;
                        end
                        else
                        begin
                            state_reg <= esm_pkg::S_VIC2;
                        end
                    end
                end
                esm_pkg::S_VIC2:
                begin
                    if (scan_done)
                    begin
                        if (scan_found)
                        begin
                            tgt_reg   <= scan_idx;
                            kind_reg  <= esm_pkg::K_VICT;
                            state_reg <= esm_pkg::S_MOD;
                        end
                        else
                        begin
                            hand_reg       <= lim;
                            res_status_reg <= esm_pkg::ST_NOVICTIM;
                            state_reg      <= esm_pkg::S_FIN;
                        end
                    end
                end
                esm_pkg::S_MOD:
                begin
                    state_reg    <= esm_pkg::S_FIN;
                    res_slot_reg <= esm_pkg::PSLOT_W'(tgt_reg);
                    case (kind_reg)
                        esm_pkg::K_HIT:
                        begin
                            res_status_reg <= esm_pkg::ST_HIT;
                        end
                        esm_pkg::K_REM:
                        begin
                            res_status_reg <= esm_pkg::ST_DONE;
                        end
                        esm_pkg::K_FILL:
                        begin
                            res_status_reg <= esm_pkg::ST_PLACED;
                            filled_reg     <= filled_reg + 1'b1;
                        end
                        esm_pkg::K_VICT:
                        begin
                            res_status_reg <= esm_pkg::ST_PLACED;
                            hand_reg       <= CNT_W'(tgt_reg) + 1'b1;
                            // a slot emptied by remove hands back no key
                            if (newest_key != esm_pkg::KEY_INVALID)
                            begin
                                res_swap_reg <= 1'b1;
                                res_key_reg  <= newest_key;
                            end
                        end
                        default:
                        begin
                            if (gk_found)
                            begin
                                res_status_reg <= esm_pkg::ST_HIT;
                                res_key_reg    <= gk_key;
                            end
                            else
                            begin
                                res_status_reg <= esm_pkg::ST_NOTFOUND;
                                res_slot_reg   <= '0;
                            end
                        end
                    endcase
                end
                esm_pkg::S_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {3'b000, res_key_reg, res_swap_reg, res_slot_reg};
                        state_reg    <= esm_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= esm_pkg::S_IDLE;
                end
            endcase
            // configuration writes; writing the start offset rewinds fill and hand
            if (cfg_we)
            begin
                unique case (cfg_index)
                    esm_pkg::CFG_SLOTS_USED:
                    begin
                        csu_reg <= cfg_data;
                    end
                    esm_pkg::CFG_RES_START:
                    begin
                        rstart_reg <= cfg_data[11:0];
                        filled_reg <= CNT_W'(cfg_data[11:0]);
                        hand_reg   <= CNT_W'(cfg_data[11:0]);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
